// ----- rtl/enr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package enr_pkg;

    // Node id space and the widths that follow from it.
    localparam int MAX_NODES = 1024;
    localparam int SLOT_W    = $clog2(MAX_NODES);

    // Fixed field widths of the stream interface.
    localparam int ID_W      = 11;
    localparam int CNT_W     = 11;
    localparam int CAP_W     = 64;
    localparam int S_DATA_W  = 88;
    localparam int M_DATA_W  = 104;
    localparam int M_USER_W  = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // write zero into the forward table at the sweep index
        logic capture;   // take the input transfer into the working registers
        logic tbl_rd;    // read the forward table at the current endpoint slot
        logic rev_rd;    // read the reverse table at the label just read
        logic resolve;   // decide hit or fresh label, write both tables on a miss
        logic sel_b;     // work on the second endpoint instead of the first
        logic load_out;  // move the finished result into the output register
    } enr_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/enr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module enr_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [enr_pkg::CNT_W-1:0]     cfg_wdata,
    input  wire logic [enr_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          s_tlast,
    input  wire enr_pkg::enr_cmd_t             cmd,
    output logic                               ids_ok,
    output logic                               clr_last,
    output logic [enr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [enr_pkg::M_USER_W-1:0]       m_tuser,
    output logic                               m_tlast
);
    import enr_pkg::*;

    // Forward table: old id slot to label minus one. Reverse table: label minus
    // one to old id slot. A forward entry counts only when its label does not
    // exceed the current count and the reverse entry points back at the same slot,
    // so neither table needs clearing between lists. The forward table is swept
    // to zero once after reset so that every lookup reads a defined label.
    logic [SLOT_W-1:0] tbl_mem [MAX_NODES];
    logic [SLOT_W-1:0] rev_mem [MAX_NODES];

    logic [SLOT_W-1:0] clr_idx_reg;

    logic [CNT_W-1:0]  node_count_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [ID_W-1:0]   a_reg;
    logic [ID_W-1:0]   b_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic              last_reg;
    logic              err_reg;

    logic [CNT_W-1:0]  la_reg;
    logic [CNT_W-1:0]  lb_reg;
    logic              fa_reg;
    logic              fb_reg;

    logic [SLOT_W-1:0] tbl_q_reg;
    logic [SLOT_W-1:0] rev_q_reg;

    logic [CNT_W-1:0]  out_la_reg;
    logic [CNT_W-1:0]  out_lb_reg;
    logic [CAP_W-1:0]  out_cap_reg;
    logic              out_fa_reg;
    logic              out_fb_reg;
    logic [CNT_W-1:0]  out_used_reg;
    logic              out_err_reg;
    logic              out_last_reg;

    logic [ID_W-1:0]   in_a;
    logic [ID_W-1:0]   in_b;
    logic [ID_W-1:0]   cur_id;
    logic [SLOT_W-1:0] cur_slot;
    logic [ID_W-1:0]   cur_slot_wide;
    logic              hit;
    logic [CNT_W-1:0]  label;

    assign in_a = s_tdata[ID_W-1:0];
    assign in_b = s_tdata[2*ID_W-1:ID_W];

    function automatic logic id_valid(input logic [ID_W-1:0] id,
                                      input logic [CNT_W-1:0] limit);
        return (id != '0) && (id <= limit) && (id <= ID_W'(MAX_NODES));
    endfunction

    assign ids_ok = id_valid(in_a, node_count_reg) && id_valid(in_b, node_count_reg);

    assign clr_last = (clr_idx_reg == SLOT_W'(MAX_NODES - 1));

    assign cur_id        = cmd.sel_b ? b_reg : a_reg;
    assign cur_slot_wide = cur_id - ID_W'(1);
    assign cur_slot      = cur_slot_wide[SLOT_W-1:0];

    assign hit   = (CNT_W'(tbl_q_reg) < count_reg) && (rev_q_reg == cur_slot);
    assign label = hit ? (CNT_W'(tbl_q_reg) + CNT_W'(1)) : (count_reg + CNT_W'(1));

    always_comb begin
        count_next = count_reg;
        if (cmd.resolve && !hit) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.load_out && last_reg) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CNT_W'(1024);
            count_reg      <= '0;
            clr_idx_reg    <= '0;
        end else begin
            if (cfg_we) begin
                node_count_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
            end
        end
    end

    // Table ports: one registered read and one write each.
    always_ff @(posedge aclk) begin
        if (cmd.tbl_rd) begin
            tbl_q_reg <= tbl_mem[cur_slot];
        end
        if (cmd.clear) begin
            tbl_mem[clr_idx_reg] <= '0;
        end else if (cmd.resolve && !hit) begin
            tbl_mem[cur_slot] <= count_reg[SLOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rev_rd) begin
            rev_q_reg <= rev_mem[tbl_q_reg];
        end
        if (cmd.resolve && !hit) begin
            rev_mem[count_reg[SLOT_W-1:0]] <= cur_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            a_reg    <= in_a;
            b_reg    <= in_b;
            cap_reg  <= s_tdata[2*ID_W+CAP_W-1:2*ID_W];
            last_reg <= s_tlast;
            err_reg  <= !ids_ok;
            la_reg   <= '0;
            lb_reg   <= '0;
            fa_reg   <= 1'b0;
            fb_reg   <= 1'b0;
        end
        if (cmd.resolve) begin
            if (cmd.sel_b) begin
                lb_reg <= label;
                fb_reg <= !hit;
            end else begin
                la_reg <= label;
                fa_reg <= !hit;
            end
        end
        if (cmd.load_out) begin
            out_la_reg   <= la_reg;
            out_lb_reg   <= lb_reg;
            out_cap_reg  <= cap_reg;
            out_fa_reg   <= fa_reg;
            out_fb_reg   <= fb_reg;
            out_used_reg <= count_reg;
            out_err_reg  <= err_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_tdata = {(M_DATA_W - 2*CNT_W - CAP_W - CNT_W)'(0), out_used_reg,
                      out_cap_reg, out_lb_reg, out_la_reg};
    assign m_tuser = {out_err_reg, out_fb_reg, out_fa_reg};
    assign m_tlast = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/enr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module enr_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire logic           ids_ok,
    input  wire logic           clr_last,
    output enr_pkg::enr_cmd_t   cmd
);
    import enr_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_REV,
        S_RES,
        S_FIN
    } state_t;

    state_t state_reg;
    logic   sel_b_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.sel_b    = sel_b_reg;
        cmd.clear    = (state_reg == S_CLEAR);
        cmd.capture  = (state_reg == S_IDLE) && s_tvalid;
        cmd.tbl_rd   = (state_reg == S_RD);
        cmd.rev_rd   = (state_reg == S_REV);
        cmd.resolve  = (state_reg == S_RES);
        cmd.load_out = (state_reg == S_FIN) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            sel_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    if (clr_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        sel_b_reg <= 1'b0;
                        state_reg <= ids_ok ? S_RD : S_FIN;
                    end
                end
                S_RD: begin
                    state_reg <= S_REV;
                end
                S_REV: begin
                    state_reg <= S_RES;
                end
                S_RES: begin
                    if (sel_b_reg) begin
                        state_reg <= S_FIN;
                    end else begin
                        sel_b_reg <= 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/edge_node_relabeler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   88     one edge: two old node ids, capacity word; tlast ends the list
// m_axis    out  104    one result per edge: labels, capacity, count; tuser flags
// cfg       in   11     node_count, written with cfg_we
//
// After reset the forward table is swept to zero, one entry a cycle, with
// s_tready low. A valid edge resolves endpoint_a, then endpoint_b, and its
// result is loaded into the output register before the next edge is taken;
// an edge with a bad id goes straight to the load. Each endpoint costs a
// forward table read, a reverse table read and a resolve step, all on single-port reads.
// Reset clears the label count and restores node_count to 1024.
// A result waits in the output register while the next edge is taken in; the
// controller stalls before loading only if that register is still occupied.

module edge_node_relabeler (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // Configuration: node_count.
    input  wire logic                          cfg_we,
    input  wire logic [enr_pkg::CNT_W-1:0]     cfg_wdata,

    // Input edges.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata fields from bit 0: endpoint_a[10:0], endpoint_b[21:11],
    // capacity_bits[85:22], zero fill[87:86].
    input  wire logic [enr_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          s_tlast,    // last_edge

    // Relabeled edges.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata fields from bit 0: label_a[10:0], label_b[21:11],
    // capacity_out[85:22], labels_used[96:86], zero fill[103:97].
    output logic [enr_pkg::M_DATA_W-1:0]       m_tdata,
    // m_tuser fields from bit 0: first_seen_a, first_seen_b, id_error.
    output logic [enr_pkg::M_USER_W-1:0]       m_tuser,
    output logic                               m_tlast     // last_out
);
    import enr_pkg::*;

    // The controller sequences the table sweep and the two lookups of each edge;
    // the datapath holds the tables, the count and the result register. They
    // talk only through the command struct, the id check of the incoming
    // transfer and the end-of-sweep status.
    enr_cmd_t cmd;
    logic     ids_ok;
    logic     clr_last;

    enr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ids_ok   (ids_ok),
        .clr_last (clr_last),
        .cmd      (cmd)
    );

    enr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .ids_ok    (ids_ok),
        .clr_last  (clr_last),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
